FILE: design/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

    // Table size and derived index width
    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Field widths
    localparam int OP_W   = 2;
    localparam int KIND_W = 2;
    localparam int TIME_W = 48;
    localparam int ID_W   = 31;
    localparam int MS_W   = 31;
    localparam int TAG_W  = 16;

    // Stream data widths (fields packed from bit 0, padded to bytes)
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 48;

    // Milliseconds to microseconds: 1000 fits in 10 bits
    localparam int             US_W      = 10;
    localparam int             PROD_W    = MS_W + US_W;
    localparam logic [US_W-1:0] US_PER_MS = 10'd1000;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
    localparam logic [ID_W-1:0] ID_ONE = {{(ID_W-1){1'b0}}, 1'b1};

    // Operation codes
    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CREATED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJ_ZERO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJ_FULL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd3;

    // One slot of the timer table as held in memory
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [MS_W-1:0]   interval;
        logic              periodic;
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } ptt_entry_t;

    localparam int ENTRY_W = $bits(ptt_entry_t);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic idx_clear;
        logic idx_inc;
        logic rd_en;
        logic mul_create;
        logic mul_tick;
        logic cr_commit;
        logic cancel_hit;
        logic fire;
        logic flush;
        logic clear_all;
    } ptt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic slot_active;
        logic idx_last;
        logic out_free;
        logic id_match;
        logic expired;
        logic pend_valid;
    } ptt_stat_t;

    // Saturating deadline: time plus product, clamped to the top of the time range
    function automatic logic [TIME_W-1:0] deadline_add(
        input logic [TIME_W-1:0] t,
        input logic [PROD_W-1:0] p
    );
        logic [TIME_W:0] sum;
        sum = {1'b0, t} + {{(TIME_W + 1 - PROD_W){1'b0}}, p};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/ptt_ram.sv
`default_nettype none

module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, held between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/ptt_ctrl.sv
`default_nettype none

module ptt_ctrl
    import ptt_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [OP_W-1:0] in_op,
    output logic                 in_ready,
    input  wire ptt_stat_t       stat,
    output ptt_cmd_t             cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CR_MUL  = 4'd1;
    localparam logic [3:0] ST_CR_DONE = 4'd2;
    localparam logic [3:0] ST_CN_SCAN = 4'd3;
    localparam logic [3:0] ST_CN_CHK  = 4'd4;
    localparam logic [3:0] ST_TK_SCAN = 4'd5;
    localparam logic [3:0] ST_TK_CHK  = 4'd6;
    localparam logic [3:0] ST_TK_FIRE = 4'd7;
    localparam logic [3:0] ST_TK_END  = 4'd8;
    localparam logic [3:0] ST_CLR     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Sequence each operation over the slots
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.idx_clear = 1'b1;
                    case (in_op)
                        OP_CREATE: state_next = ST_CR_MUL;
                        OP_CANCEL: state_next = ST_CN_SCAN;
                        OP_TICK:   state_next = ST_TK_SCAN;
                        default:   state_next = ST_CLR;
                    endcase
                end
            end
            ST_CR_MUL:
            begin
                cmd.mul_create = 1'b1;
                state_next     = ST_CR_DONE;
            end
            ST_CR_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.cr_commit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CN_SCAN:
            begin
                if (stat.slot_active)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CN_CHK;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_CN_CHK:
            begin
                if (stat.id_match)
                begin
                    cmd.cancel_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_CN_SCAN;
                end
            end
            ST_TK_SCAN:
            begin
                if (stat.slot_active)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_TK_CHK;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_TK_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_TK_CHK:
            begin
                if (stat.expired)
                begin
                    cmd.mul_tick = 1'b1;
                    state_next   = ST_TK_FIRE;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_TK_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_TK_SCAN;
                end
            end
            ST_TK_FIRE:
            begin
                // Hold until the previous fired beat can leave
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.fire = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = ST_TK_END;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_TK_SCAN;
                    end
                end
            end
            ST_TK_END:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                cmd.clear_all = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/ptt_dp.sv
`default_nettype none

module ptt_dp
    import ptt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ptt_cmd_t          cmd,
    output ptt_stat_t              stat,
    input  wire logic [TIME_W-1:0] in_now,
    input  wire logic [MS_W-1:0]   in_ms,
    input  wire logic              in_periodic,
    input  wire logic [ID_W-1:0]   in_cancel_id,
    input  wire logic [TAG_W-1:0]  in_tag,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [KIND_W-1:0]      out_kind,
    output logic [ID_W-1:0]        out_id,
    output logic [TAG_W-1:0]       out_tag,
    output logic                   out_last
);

    // Captured input item
    logic [TIME_W-1:0] item_now_reg;
    logic [MS_W-1:0]   item_ms_reg;
    logic              item_per_reg;
    logic [ID_W-1:0]   item_cid_reg;
    logic [TAG_W-1:0]  item_tag_reg;

    logic [SLOT_W-1:0]    idx_reg;
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] active_next;
    logic [ID_W-1:0]      next_id_reg;
    logic [ID_W-1:0]      next_id_next;

    logic [PROD_W-1:0] prod_reg;
    logic [MS_W-1:0]   mul_src;
    logic [SLOT_W-1:0] free_idx_reg;
    logic              full_reg;
    logic [SLOT_W-1:0] free_idx;
    logic              free_found;

    logic              pend_valid_reg;
    logic [ID_W-1:0]   pend_id_reg;
    logic [TAG_W-1:0]  pend_tag_reg;

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic              out_last_reg;

    logic [ENTRY_W-1:0] ram_rd_data;
    ptt_entry_t         rd_entry;
    ptt_entry_t         new_entry;
    ptt_entry_t         wr_entry;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [TIME_W-1:0]  dl_sum;
    logic               create_ok;
    logic               push;

    // Latch the item on acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_now_reg <= in_now;
            item_ms_reg  <= in_ms;
            item_per_reg <= in_periodic;
            item_cid_reg <= in_cancel_id;
            item_tag_reg <= in_tag;
        end
    end

    // Slot scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + SLOT_W'(1);
        end
    end

    // Find the lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign rd_entry = ptt_entry_t'(ram_rd_data);

    // Shared interval-to-microseconds multiplier, registered
    assign mul_src = cmd.mul_create ? item_ms_reg : rd_entry.interval;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_create || cmd.mul_tick)
        begin
            prod_reg <= PROD_W'(mul_src) * PROD_W'(US_PER_MS);
        end
        if (cmd.mul_create)
        begin
            free_idx_reg <= free_idx;
            full_reg     <= !free_found;
        end
    end

    assign dl_sum    = deadline_add(item_now_reg, prod_reg);
    assign create_ok = cmd.cr_commit && (item_ms_reg != '0) && !full_reg;

    // Build memory writes: new timer or periodic reload
    always_comb
    begin
        new_entry.id       = next_id_reg;
        new_entry.interval = item_ms_reg;
        new_entry.periodic = item_per_reg;
        new_entry.deadline = dl_sum;
        new_entry.tag      = item_tag_reg;
        wr_entry           = rd_entry;
        wr_entry.deadline  = dl_sum;
        if (cmd.cr_commit)
        begin
            wr_entry = new_entry;
        end
    end

    assign wr_en   = create_ok || (cmd.fire && rd_entry.periodic);
    assign wr_addr = cmd.cr_commit ? free_idx_reg : idx_reg;

    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // Slot active bits
    always_comb
    begin
        active_next = active_reg;
        if (cmd.clear_all)
        begin
            active_next = '0;
        end
        if (create_ok)
        begin
            active_next[free_idx_reg] = 1'b1;
        end
        if (cmd.cancel_hit || (cmd.fire && !rd_entry.periodic))
        begin
            active_next[idx_reg] = 1'b0;
        end
    end

    // Identifier counter, wraps back to one
    always_comb
    begin
        next_id_next = next_id_reg;
        if (cmd.clear_all)
        begin
            next_id_next = ID_ONE;
        end
        else if (create_ok)
        begin
            if (next_id_reg == ID_MAX || next_id_reg == '0)
            begin
                next_id_next = ID_ONE;
            end
            else
            begin
                next_id_next = next_id_reg + ID_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            next_id_reg <= ID_ONE;
        end
        else
        begin
            active_reg  <= active_next;
            next_id_reg <= next_id_next;
        end
    end

    // Hold the latest fired slot until the next one shows whether it was the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.fire)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (cmd.flush)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            pend_id_reg  <= rd_entry.id;
            pend_tag_reg <= rd_entry.tag;
        end
    end

    // Output register
    assign push = cmd.cr_commit || ((cmd.fire || cmd.flush) && pend_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cr_commit)
        begin
            out_tag_reg  <= '0;
            out_last_reg <= 1'b1;
            if (item_ms_reg == '0)
            begin
                out_kind_reg <= KIND_REJ_ZERO;
                out_id_reg   <= '0;
            end
            else if (full_reg)
            begin
                out_kind_reg <= KIND_REJ_FULL;
                out_id_reg   <= '0;
            end
            else
            begin
                out_kind_reg <= KIND_CREATED;
                out_id_reg   <= next_id_reg;
            end
        end
        else if (push)
        begin
            out_kind_reg <= KIND_FIRED;
            out_id_reg   <= pend_id_reg;
            out_tag_reg  <= pend_tag_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_id    = out_id_reg;
    assign out_tag   = out_tag_reg;
    assign out_last  = out_last_reg;

    // Status to the controller
    assign stat.slot_active = active_reg[idx_reg];
    assign stat.idx_last    = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign stat.id_match    = (rd_entry.id == item_cid_reg);
    assign stat.expired     = (item_now_reg >= rd_entry.deadline);
    assign stat.pend_valid  = pend_valid_reg;

endmodule

`default_nettype wire

FILE: design/periodic_timer_table.sv
// Table of up to NUM_SLOTS software timers, one-shot or periodic, with one
// operation per input beat: create (one result: created, zero interval or
// table full), cancel (no result), tick (one fired beat per expired slot in
// slot order, tlast on the final one, none if nothing expires) and clear (no
// result). One item is processed at a time; the slot store is a single
// memory with a registered read, so every scan walks the slots one by one.
// Create multiplies and then commits; clear resets every slot at once.
// Cancel reads each active slot in turn and stops at the first match. Tick
// reads each active slot, fires the expired ones and then flushes the last
// fired beat. Back pressure on the result side stalls create and tick.
// No clearing pass after reset is needed.
`default_nettype none

module periodic_timer_table
    import ptt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // now_time_us[47:0], period_ms[78:48], periodic[79], cancel_id[110:80],
    // user_tag[126:111], zero pad[127]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  wire logic [OP_W-1:0]       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // ident[30:0], fired_tag[46:31], zero pad[47]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // kind[1:0]
    output logic [KIND_W-1:0]          m_axis_tuser,
    output logic                       m_axis_tlast
);

    ptt_cmd_t          cmd;
    ptt_stat_t         stat;
    logic [ID_W-1:0]   out_id;
    logic [TAG_W-1:0]  out_tag;

    ptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_now       (s_axis_tdata[47:0]),
        .in_ms        (s_axis_tdata[78:48]),
        .in_periodic  (s_axis_tdata[79]),
        .in_cancel_id (s_axis_tdata[110:80]),
        .in_tag       (s_axis_tdata[126:111]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_kind     (m_axis_tuser),
        .out_id       (out_id),
        .out_tag      (out_tag),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_tag, out_id};

    // One item at a time: no new beat right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    // A create result never overwrites a waiting beat
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cr_commit |-> stat.out_free)
        else $error("create result pushed into a full output register");

    // A held fired beat moves out only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fire || cmd.flush) && stat.pend_valid |-> stat.out_free)
        else $error("fired result pushed into a full output register");

    // Scan commands stay exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.cr_commit, cmd.cancel_hit, cmd.fire, cmd.flush, cmd.clear_all}))
        else $error("conflicting table update commands");

endmodule

`default_nettype wire
